// File: hw/rtl/cst_pkg.sv
// Shared constants, types and character-class functions of the stream tokenizer.
`default_nettype none

package cst_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int FIELD_W     = 16;
    localparam int KIND_W      = 5;
    localparam int EXT_W       = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 1;
    localparam int FIELD_MAX   = (2 ** FIELD_W) - 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int NUM_SPECIAL = 17;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_NUM   = 2'd2;
    localparam logic [1:0] MODE_HALT  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_IDENT        = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NUM          = 5'd1;
    localparam logic [KIND_W-1:0] KIND_INVALID      = 5'd2;
    localparam logic [KIND_W-1:0] KIND_SPECIAL_BASE = 5'd3;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_UPPER_E    = 8'h45;
    localparam logic [7:0] CH_LOWER_E    = 8'h65;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    // ( ) [ ] { } < > = + - * / ^ , : ;  in token-kind order
    localparam logic [7:0] SPECIAL_CHARS [NUM_SPECIAL] = '{
        8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h3D,
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E, 8'h2C, 8'h3A, 8'h3B
    };

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
    } t_token;

    // Tokens caused by one request; the first slot is always used.
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_entry;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [FIELD_W-1:0] sat_field(input logic [EXT_W-1:0] v);
        if (v > EXT_W'(FIELD_MAX)) begin
            return '1;
        end
        return v[FIELD_W-1:0];
    endfunction

    // A zero length still counts as one character.
    function automatic logic [FIELD_W-1:0] token_len(input logic [EXT_W-1:0] v);
        if (v == '0) begin
            return FIELD_W'(1);
        end
        return sat_field(v);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cst_if.sv
// Valid/ready channel interfaces for input bytes and output tokens.
`default_nettype none

interface cst_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface cst_tok_if;
    logic                         valid;
    logic                         ready;
    logic [cst_pkg::KIND_W-1:0]   token_kind;
    logic [cst_pkg::FIELD_W-1:0]  token_start;
    logic [cst_pkg::FIELD_W-1:0]  token_length;
    logic                         run_last;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output run_last, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input run_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/char_stream_tokenizer.sv
// Top level of the streaming character tokenizer.
`default_nettype none

//  Channel  | Dir | Payload                                          | Handshake
//  i_byte   | in  | ch[7:0], end_of_text                             | valid/ready
//  o_tok    | out | token_kind[4:0], token_start[15:0],              | valid/ready
//           |     | token_length[15:0], run_last                     |
//
// One byte request is taken every cycle while the token queue has room; its
// tokens are registered in the queue and reach o_tok after the entries ahead of them.
// The output sends one token per cycle while o_tok.ready is high, so a byte that
// yields two tokens holds the output for both; the four-entry queue absorbs such bursts.
// A synchronous active-low reset returns the scanner to idle at offset zero
// and empties the queue.
// A stall on o_tok backs up only through the queue: i_byte.ready falls when
// the queue is full, never because a token is waiting on the output.
module char_stream_tokenizer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cst_byte_if.sink  i_byte,
    cst_tok_if.source o_tok
);
    import cst_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry entry_in;
    t_entry head;

    // The front end scans each byte and forms the entry of tokens it causes.
    cst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry_in)
    );

    // The queue decouples scanning from token delivery.
    cst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // The back end streams out the tokens of each entry in order.
    cst_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_tok   (o_tok)
    );

endmodule

`default_nettype wire

// File: hw/rtl/cst_front.sv
// Front end: accepts bytes, runs the scanner state and builds token entries.
`default_nettype none

module cst_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    cst_byte_if.sink            i_byte,
    input  wire logic           i_full,
    output logic                o_push,
    output cst_pkg::t_entry     o_entry
);
    import cst_pkg::*;

    logic [1:0]             r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic                   r_dot, n_dot;
    logic                   r_exp, n_exp;

    logic                   accept;
    logic [7:0]             c;
    logic                   c_is_exp;
    logic                   c_in_num;
    logic                   consumed;
    logic                   spec_hit;
    logic [KIND_W-1:0]      spec_kind;
    logic                   a_valid, b_valid;
    t_token                 tok_a, tok_b;
    logic [1:0]             mode_mid;
    logic [OFFSET_BITS-1:0] diff_pend;
    logic [OFFSET_BITS-1:0] diff_last;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;
    assign c            = i_byte.ch;
    assign c_is_exp     = (c == CH_UPPER_E) || (c == CH_LOWER_E);
    assign c_in_num     = is_digit(c) || c == CH_DOT || c_is_exp ||
                          c == CH_PLUS || c == CH_MINUS;
    assign diff_pend    = r_pos - r_start;

    always_comb begin
        spec_hit  = 1'b0;
        spec_kind = KIND_INVALID;
        for (int i = 0; i < NUM_SPECIAL; i++) begin
            if (c == SPECIAL_CHARS[i]) begin
                spec_hit  = 1'b1;
                spec_kind = KIND_SPECIAL_BASE + KIND_W'(i);
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_dot    = r_dot;
        n_exp    = r_exp;
        n_pos    = r_pos;
        consumed = 1'b0;
        a_valid  = 1'b0;
        b_valid  = 1'b0;
        tok_a    = '{kind: KIND_IDENT, start: sat_field(EXT_W'(r_start)),
                     length: token_len(EXT_W'(diff_pend))};
        tok_b    = '{kind: KIND_INVALID, start: sat_field(EXT_W'(r_pos)),
                     length: FIELD_W'(1)};

        // A pending token either takes the byte or is closed by it.
        case (r_mode)
            MODE_IDENT: begin
                if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                    consumed = 1'b1;
                end else begin
                    a_valid = 1'b1;
                    n_mode  = MODE_IDLE;
                end
            end
            MODE_NUM: begin
                if (c_in_num && !(c == CH_DOT && r_dot) && !(c_is_exp && r_exp)) begin
                    consumed = 1'b1;
                    if (c == CH_DOT) begin
                        n_dot = 1'b1;
                    end
                    if (c_is_exp) begin
                        n_exp = 1'b1;
                    end
                end else begin
                    a_valid    = 1'b1;
                    tok_a.kind = KIND_NUM;
                    n_mode     = MODE_IDLE;
                end
            end
            default: begin
            end
        endcase

        // A byte that no pending token took is scanned as the start of a new token.
        if (!consumed && n_mode == MODE_IDLE) begin
            if (is_space(c)) begin
            end else if (is_letter(c)) begin
                n_mode  = MODE_IDENT;
                n_start = r_pos;
            end else if (is_digit(c)) begin
                n_mode  = MODE_NUM;
                n_start = r_pos;
                n_dot   = 1'b0;
                n_exp   = 1'b0;
            end else if (spec_hit) begin
                b_valid    = 1'b1;
                tok_b.kind = spec_kind;
            end else begin
                b_valid = 1'b1;
                n_mode  = MODE_HALT;
            end
        end
        mode_mid  = n_mode;
        diff_last = r_pos - n_start;

        if (i_byte.end_of_text) begin
            // The last byte flushes a pending token, byte included.
            if (mode_mid == MODE_IDENT || mode_mid == MODE_NUM) begin
                b_valid      = 1'b1;
                tok_b.kind   = (mode_mid == MODE_IDENT) ? KIND_IDENT : KIND_NUM;
                tok_b.start  = sat_field(EXT_W'(n_start));
                tok_b.length = token_len(EXT_W'(diff_last) + EXT_W'(1));
            end
            n_mode  = MODE_IDLE;
            n_start = '0;
            n_pos   = '0;
            n_dot   = 1'b0;
            n_exp   = 1'b0;
        end else if (r_pos != '1) begin
            n_pos = r_pos + OFFSET_BITS'(1);
        end
    end

    assign o_push        = accept && (a_valid || b_valid);
    assign o_entry.tok0  = a_valid ? tok_a : tok_b;
    assign o_entry.tok1  = tok_b;
    assign o_entry.two   = a_valid && b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_dot   <= 1'b0;
            r_exp   <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_dot   <= n_dot;
            r_exp   <= n_exp;
        end
    end

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HALT && !i_byte.end_of_text) |-> !o_push)
        else $error("halted scanner produced a token");

    a_pos_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_byte.end_of_text) |=> (r_pos == '0 && r_mode == MODE_IDLE))
        else $error("scanner state not cleared after last byte");

endmodule

`default_nettype wire

// File: hw/rtl/cst_fifo.sv
// Short queue of token entries between the front and back ends.
`default_nettype none

module cst_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cst_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output cst_pkg::t_entry      o_head
);
    import cst_pkg::*;

    t_entry           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W + 1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PTR_W + 1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full token queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty token queue");

endmodule

`default_nettype wire

// File: hw/rtl/cst_back.sv
// Back end: sends the one or two tokens of each queued entry, one per cycle while o_tok.ready is high.
`default_nettype none

module cst_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire cst_pkg::t_entry i_head,
    output logic                 o_pop,
    cst_tok_if.source            o_tok
);
    import cst_pkg::*;

    logic   r_sub;
    t_token cur;
    logic   fire;

    assign cur                = r_sub ? i_head.tok1 : i_head.tok0;
    assign o_tok.valid        = !i_empty;
    assign o_tok.token_kind   = cur.kind;
    assign o_tok.token_start  = cur.start;
    assign o_tok.token_length = cur.length;
    assign o_tok.run_last     = r_sub || !i_head.two;
    assign fire               = o_tok.valid && o_tok.ready;
    assign o_pop              = fire && o_tok.run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (fire) begin
            r_sub <= !o_tok.run_last;
        end
    end

    a_sub_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (!i_empty && i_head.two))
        else $error("second slot selected without a two-token entry");

endmodule

`default_nettype wire
